// File: rtl/qvr_pkg.sv
// Shared types and widths for the quaternion vector rotation pipeline.
// No dependencies; compiled first.
`default_nettype none

package qvr_pkg;

	localparam int unsigned FIELD_W    = 16;
	// p * conj(q): products of two fields, sums of three products
	localparam int unsigned PROD1_W    = 2 * FIELD_W;
	localparam int unsigned MID_W      = PROD1_W + 1;
	// q * mid: field times mid, sums of four products
	localparam int unsigned PROD2_W    = FIELD_W + MID_W;
	localparam int unsigned RES_W      = PROD2_W + 2;
	localparam int unsigned FRAC_SHIFT = 2 * (FIELD_W - 2);
	localparam int unsigned RQ_W       = RES_W - FRAC_SHIFT;
	localparam int unsigned NSTG       = 5;
	localparam int unsigned NPROD      = 12;

	localparam logic signed [FIELD_W-1:0] OUT_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic signed [FIELD_W-1:0] OUT_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

	typedef logic signed [FIELD_W-1:0] fld_t;
	typedef logic signed [PROD1_W-1:0] prod1_t;
	typedef logic signed [MID_W-1:0]   mid_t;
	typedef logic signed [PROD2_W-1:0] prod2_t;
	typedef logic signed [RES_W-1:0]   res_t;

	typedef struct packed {
		fld_t w;
		fld_t x;
		fld_t y;
		fld_t z;
	} quat_t;

	// per-stage load enables from the pipeline control
	typedef struct packed {
		logic [NSTG-1:0] en;
	} pipe_ctl_t;

endpackage

`default_nettype wire

// File: rtl/qvr_in_if.sv
// Input channel: quaternion and vector with valid/ready.
// Depends on qvr_pkg.
`default_nettype none

interface qvr_in_if import qvr_pkg::*; ();
	logic valid;
	logic ready;
	fld_t quat_w;
	fld_t quat_x;
	fld_t quat_y;
	fld_t quat_z;
	fld_t vec_x;
	fld_t vec_y;
	fld_t vec_z;

	modport source (
		output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
		input  ready
	);
	modport sink (
		input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/qvr_out_if.sv
// Output channel: rotated vector and clip flag with valid/ready.
// Depends on qvr_pkg.
`default_nettype none

interface qvr_out_if import qvr_pkg::*; ();
	logic valid;
	logic ready;
	fld_t rot_x;
	fld_t rot_y;
	fld_t rot_z;
	logic clipped;

	modport source (
		output valid, rot_x, rot_y, rot_z, clipped,
		input  ready
	);
	modport sink (
		input  valid, rot_x, rot_y, rot_z, clipped,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/qvr_ctrl.sv
// Pipeline valid bits and per-stage load enables (bubbles collapse).
// Depends on qvr_pkg.
`default_nettype none

module qvr_ctrl import qvr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      out_ready,
	output logic      out_valid,
	output pipe_ctl_t ctl
);

	logic [NSTG-1:0] vld_q;

	// a stage loads when empty or when its content moves on
	always_comb begin
		ctl.en[NSTG-1] = !vld_q[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			ctl.en[k] = !vld_q[k] || ctl.en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctl.en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (ctl.en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = ctl.en[0];
	assign out_valid = vld_q[NSTG-1];

endmodule

`default_nettype wire

// File: rtl/qvr_mid.sv
// Stages 1-2: mid = (0,v) * conj(q); products, then three-term sums.
// Depends on qvr_pkg.
`default_nettype none

module qvr_mid import qvr_pkg::*; (
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  quat_t     quat,
	input  fld_t      vec_x,
	input  fld_t      vec_y,
	input  fld_t      vec_z,
	output quat_t     quat_s2,
	output mid_t      mid_s2 [4]
);

	prod1_t prd_s1 [NPROD];
	quat_t  quat_s1;

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			quat_s1    <= quat;
			// scalar: v . qv
			prd_s1[0]  <= vec_x * quat.x;
			prd_s1[1]  <= vec_y * quat.y;
			prd_s1[2]  <= vec_z * quat.z;
			// i
			prd_s1[3]  <= quat.w * vec_x;
			prd_s1[4]  <= vec_y * quat.z;
			prd_s1[5]  <= vec_z * quat.y;
			// j
			prd_s1[6]  <= quat.w * vec_y;
			prd_s1[7]  <= vec_z * quat.x;
			prd_s1[8]  <= vec_x * quat.z;
			// k
			prd_s1[9]  <= quat.w * vec_z;
			prd_s1[10] <= vec_x * quat.y;
			prd_s1[11] <= vec_y * quat.x;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			quat_s2   <= quat_s1;
			mid_s2[0] <= MID_W'(prd_s1[0]) + MID_W'(prd_s1[1]) + MID_W'(prd_s1[2]);
			mid_s2[1] <= MID_W'(prd_s1[3]) - MID_W'(prd_s1[4]) + MID_W'(prd_s1[5]);
			mid_s2[2] <= MID_W'(prd_s1[6]) - MID_W'(prd_s1[7]) + MID_W'(prd_s1[8]);
			mid_s2[3] <= MID_W'(prd_s1[9]) - MID_W'(prd_s1[10]) + MID_W'(prd_s1[11]);
		end
	end

endmodule

`default_nettype wire

// File: rtl/qvr_outer.sv
// Stages 3-4: vector part of q * mid; products, then four-term sums.
// Depends on qvr_pkg.
`default_nettype none

module qvr_outer import qvr_pkg::*; (
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  quat_t     quat_s2,
	input  mid_t      mid_s2 [4],
	output res_t      res_s4 [3]
);

	prod2_t prd_s3 [NPROD];

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			// i
			prd_s3[0]  <= quat_s2.w * mid_s2[1];
			prd_s3[1]  <= quat_s2.x * mid_s2[0];
			prd_s3[2]  <= quat_s2.y * mid_s2[3];
			prd_s3[3]  <= quat_s2.z * mid_s2[2];
			// j
			prd_s3[4]  <= quat_s2.w * mid_s2[2];
			prd_s3[5]  <= quat_s2.y * mid_s2[0];
			prd_s3[6]  <= quat_s2.z * mid_s2[1];
			prd_s3[7]  <= quat_s2.x * mid_s2[3];
			// k
			prd_s3[8]  <= quat_s2.w * mid_s2[3];
			prd_s3[9]  <= quat_s2.z * mid_s2[0];
			prd_s3[10] <= quat_s2.x * mid_s2[2];
			prd_s3[11] <= quat_s2.y * mid_s2[1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			for (int c = 0; c < 3; c++) begin
				res_s4[c] <= RES_W'(prd_s3[4*c]) + RES_W'(prd_s3[4*c+1])
					+ RES_W'(prd_s3[4*c+2]) - RES_W'(prd_s3[4*c+3]);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/qvr_rndsat.sv
// Stage 5: round half up by 2^-28, saturate to 16 bits, flag clipping.
// Depends on qvr_pkg.
`default_nettype none

module qvr_rndsat import qvr_pkg::*; (
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  res_t      res_s4 [3],
	output fld_t      rot_s5 [3],
	output logic      clip_s5
);

	localparam res_t HALF = RES_W'(1) <<< (FRAC_SHIFT - 1);

	res_t                  rnd   [3];
	logic signed [RQ_W-1:0] quo  [3];
	fld_t                  sat   [3];
	logic [2:0]            ovf;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rnd[c] = res_s4[c] + HALF;
			quo[c] = rnd[c][RES_W-1:FRAC_SHIFT];
			if (quo[c] > RQ_W'(OUT_MAX)) begin
				sat[c] = OUT_MAX;
				ovf[c] = 1'b1;
			end else if (quo[c] < RQ_W'(OUT_MIN)) begin
				sat[c] = OUT_MIN;
				ovf[c] = 1'b1;
			end else begin
				sat[c] = quo[c][FIELD_W-1:0];
				ovf[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			rot_s5  <= sat;
			clip_s5 <= |ovf;
		end
	end

endmodule

`default_nettype wire

// File: rtl/quaternion_vector_rotate_top.sv
// Quaternion vector rotation: vector part of q * (0,v) * conj(q), fixed point.
// Depends on qvr_pkg, qvr_in_if, qvr_out_if, qvr_ctrl, qvr_mid, qvr_outer, qvr_rndsat.
//
// Usage:
//  - sample channel (sink): one item is a Q1.14 quaternion (quat_w..quat_z)
//    and a signed 16-bit vector (vec_x..vec_z). Taken when valid && ready.
//  - result channel (source): rot_x/y/z, rounded half up and saturated to
//    16 bits, plus clipped when any component saturated. One result per item.
//  - The quaternion is used as given; a non-unit q scales by |q|^2.
//  - Pipeline: five register stages between acceptance and result valid:
//    field products, mid sums, field-by-mid products, four-term sums,
//    round/saturate (the last is the output register).
//  - Throughput: one item per cycle while the receiver keeps ready high; each stage holds one item.
//  - Stalls: each stage loads when empty or when it empties downstream, so
//    bubbles are squeezed out and ready drops only when all five stages
//    hold items and the receiver holds ready low. Nothing is lost or repeated.
//  - Reset (arst_n low, asynchronous): all stage valid bits clear, so the
//    pipeline is empty; data registers are not reset. No configuration.
`default_nettype none

module quaternion_vector_rotate_top import qvr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	qvr_in_if.sink    sample,
	qvr_out_if.source result
);

	pipe_ctl_t ctl;
	quat_t     quat_in;
	quat_t     quat_s2;
	mid_t      mid_s2 [4];
	res_t      res_s4 [3];
	fld_t      rot_s5 [3];
	logic      clip_s5;

	assign quat_in.w = sample.quat_w;
	assign quat_in.x = sample.quat_x;
	assign quat_in.y = sample.quat_y;
	assign quat_in.z = sample.quat_z;

	// valid bits and stage enables
	qvr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.ctl       (ctl)
	);

	// stages 1-2: (0,v) * conj(q)
	qvr_mid u_mid (
		.clk     (clk),
		.ctl     (ctl),
		.quat    (quat_in),
		.vec_x   (sample.vec_x),
		.vec_y   (sample.vec_y),
		.vec_z   (sample.vec_z),
		.quat_s2 (quat_s2),
		.mid_s2  (mid_s2)
	);

	// stages 3-4: q * mid, vector part only (scale 2^28)
	qvr_outer u_outer (
		.clk     (clk),
		.ctl     (ctl),
		.quat_s2 (quat_s2),
		.mid_s2  (mid_s2),
		.res_s4  (res_s4)
	);

	// stage 5: round, saturate, output register
	qvr_rndsat u_rndsat (
		.clk     (clk),
		.ctl     (ctl),
		.res_s4  (res_s4),
		.rot_s5  (rot_s5),
		.clip_s5 (clip_s5)
	);

	assign result.rot_x   = rot_s5[0];
	assign result.rot_y   = rot_s5[1];
	assign result.rot_z   = rot_s5[2];
	assign result.clipped = clip_s5;

endmodule

`default_nettype wire
